[sv/sfs_pkg.sv]
package sfs_pkg;

  localparam int FRAMES_DEF = 64;

  localparam int ENTRY_W = 32;
  localparam int DUR_W   = 16;
  localparam int KIND_W  = 8;
  localparam int JUMP_W  = 8;
  localparam int CUR_W   = 8;
  localparam int HOLD_W  = 15;
  localparam int FCNT_W  = 7;
  localparam int OP_W    = 3;
  localparam int IDX_W   = 6;

  typedef enum logic [OP_W-1:0] {
    OP_TICK  = 3'd0,
    OP_WRITE = 3'd1,
    OP_RESET = 3'd2,
    OP_FWD   = 3'd3,
    OP_BACK  = 3'd4
  } op_t;

  localparam logic [KIND_W-1:0] KIND_JUMP_A = 8'd2;
  localparam logic [KIND_W-1:0] KIND_JUMP_B = 8'd4;
  localparam logic [KIND_W-1:0] KIND_JUMP_C = 8'd5;

  function automatic logic is_jump_kind(input logic [KIND_W-1:0] k);
    return (k == KIND_JUMP_A) || (k == KIND_JUMP_B) || (k == KIND_JUMP_C);
  endfunction

  // controller -> datapath
  typedef struct packed {
    logic start_tick;
    logic exec_op;
    logic hold_inc;
    logic step_inc;
    logic jmp1;
    logic f2_fin;
    logic f2_m1;
    logic end_fix;
    logic adv;
    logic set_hit;
    logic out_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_tick;
    logic count_zero;
    logic hold_lt;
    logic f_jump;
    logic dur_pos;
    logic cap;
    logic at_end;
    logic out_free;
  } sts_t;

endpackage

[sv/sfs_if.sv]
interface sfs_in_if import sfs_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic        [OP_W-1:0]   op;
  logic        [IDX_W-1:0]  entry_index;
  logic signed [DUR_W-1:0]  entry_duration;
  logic        [KIND_W-1:0] entry_kind;
  logic        [JUMP_W-1:0] entry_jump;

  modport source (output valid, op, entry_index, entry_duration, entry_kind, entry_jump,
                  input ready);
  modport sink (input valid, op, entry_index, entry_duration, entry_kind, entry_jump,
                output ready);
endinterface

interface sfs_out_if import sfs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CUR_W-1:0]  current_frame;
  logic [HOLD_W-1:0] hold_count;
  logic              step_limit_hit;

  modport source (output valid, current_frame, hold_count, step_limit_hit, input ready);
  modport sink (input valid, current_frame, hold_count, step_limit_hit, output ready);
endinterface

interface sfs_cfg_if import sfs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FCNT_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

[sv/sfs_ram.sv]
module sfs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[sv/sfs_ctrl.sv]
module sfs_ctrl import sfs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t st,
  output cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_CHK  = 6'b000010,
    S_F1L  = 6'b000100,
    S_F2   = 6'b001000,
    S_ADV  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (st.is_tick && !st.count_zero) begin
            cmd.start_tick = 1'b1;
            state_nxt      = S_CHK;
          end else begin
            cmd.exec_op = 1'b1;
            state_nxt   = S_DONE;
          end
        end
      end
      S_CHK: begin
        if (st.hold_lt) begin
          cmd.hold_inc = 1'b1;
          state_nxt    = S_DONE;
        end else begin
          cmd.step_inc = 1'b1;
          if (st.f_jump) begin
            cmd.jmp1  = 1'b1;
            state_nxt = S_F2;
          end else begin
            state_nxt = S_ADV;
          end
        end
      end
      S_F1L: begin
        if (st.dur_pos) begin
          state_nxt = S_DONE;
        end else if (st.cap) begin
          cmd.set_hit = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          cmd.step_inc = 1'b1;
          if (st.f_jump) begin
            cmd.jmp1  = 1'b1;
            state_nxt = S_F2;
          end else begin
            state_nxt = S_ADV;
          end
        end
      end
      S_F2: begin
        if (st.f_jump) begin
          cmd.f2_fin = 1'b1;
          state_nxt  = S_DONE;
        end else begin
          cmd.f2_m1 = 1'b1;
          state_nxt = S_ADV;
        end
      end
      S_ADV: begin
        if (st.at_end) begin
          cmd.end_fix = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          cmd.adv   = 1'b1;
          state_nxt = S_F1L;
        end
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

[sv/sfs_dp.sv]
module sfs_dp import sfs_pkg::*; #(
  parameter int FRAMES = FRAMES_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cmd_t                     cmd,
  output sts_t                     st,
  input  logic                     cfg_valid,
  input  logic [FCNT_W-1:0]        cfg_data,
  input  logic [OP_W-1:0]          op,
  input  logic [IDX_W-1:0]         entry_index,
  input  logic signed [DUR_W-1:0]  entry_duration,
  input  logic [KIND_W-1:0]        entry_kind,
  input  logic [JUMP_W-1:0]        entry_jump,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [CUR_W-1:0]         current_frame,
  output logic [HOLD_W-1:0]        hold_count,
  output logic                     step_limit_hit
);

  localparam int AW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int SW = $clog2(FRAMES + 2);
  localparam logic [8:0]    FRAMES9 = 9'(FRAMES);
  localparam logic [SW-1:0] CAP     = SW'(FRAMES + 1);

  logic [FCNT_W-1:0] fc_r;
  logic signed [8:0] cur_r, cur_nxt;
  logic [HOLD_W-1:0] hold_r, hold_nxt;
  logic [SW-1:0]     steps_r, steps_nxt;
  logic              hit_r, hit_nxt;
  logic              out_valid_r;
  logic [CUR_W-1:0]  out_cur_r;
  logic [HOLD_W-1:0] out_hold_r;
  logic              out_hit_r;

  logic [FCNT_W-1:0] cnt;
  logic signed [8:0] cnt_m1;
  logic [ENTRY_W-1:0] rdata;
  logic [JUMP_W-1:0]  rjump;
  logic [8:0]         a9, widx9, jaddr9, fwd9;
  logic               re, we;

  assign cnt    = ({2'b0, fc_r} > FRAMES9) ? FRAMES9[FCNT_W-1:0] : fc_r;
  assign cnt_m1 = $signed({2'b0, cnt}) - 9'sd1;
  assign rjump  = rdata[31:24];
  assign widx9  = {3'b0, entry_index};
  assign jaddr9 = ({1'b0, rjump} < {2'b0, cnt}) ? {1'b0, rjump} : 9'd0;
  assign fwd9   = {1'b0, cur_r[CUR_W-1:0]} + 9'd1;

  assign we = cmd.exec_op && (op_t'(op) == OP_WRITE) && (widx9 < FRAMES9);
  assign re = cmd.start_tick || cmd.jmp1 || cmd.adv;

  always_comb begin
    a9 = 9'd0;
    if (cmd.start_tick) begin
      a9 = ({1'b0, cur_r[CUR_W-1:0]} < {2'b0, cnt}) ? {1'b0, cur_r[CUR_W-1:0]} : 9'd0;
    end else if (cmd.jmp1) begin
      a9 = jaddr9;
    end else if (cmd.adv) begin
      a9 = $unsigned(cur_r + 9'sd1);
    end
  end

  sfs_ram #(.WIDTH(ENTRY_W), .DEPTH(FRAMES)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (widx9[AW-1:0]),
    .wdata ({entry_jump, entry_kind, entry_duration}),
    .re    (re),
    .raddr (a9[AW-1:0]),
    .rdata (rdata)
  );

  always_comb begin
    cur_nxt   = cur_r;
    hold_nxt  = hold_r;
    steps_nxt = steps_r;
    hit_nxt   = hit_r;
    if (cmd.start_tick) begin
      steps_nxt = '0;
      hit_nxt   = 1'b0;
    end
    if (cmd.exec_op) begin
      hit_nxt = 1'b0;
      case (op_t'(op))
        OP_RESET: begin
          cur_nxt  = '0;
          hold_nxt = '0;
        end
        OP_FWD: begin
          if (cnt != '0) begin
            cur_nxt  = (fwd9 >= {2'b0, cnt}) ? 9'sd0 : $signed(fwd9);
            hold_nxt = '0;
          end
        end
        OP_BACK: begin
          if (cnt != '0) begin
            cur_nxt  = (cur_r[CUR_W-1:0] == '0) ? cnt_m1 : cur_r - 9'sd1;
            hold_nxt = '0;
          end
        end
        default: begin
        end
      endcase
    end
    if (cmd.hold_inc) begin
      hold_nxt = hold_r + 15'd1;
    end
    if (cmd.step_inc) begin
      steps_nxt = steps_r + 1'b1;
    end
    if (cmd.jmp1) begin
      cur_nxt  = $signed({1'b0, rjump});
      hold_nxt = '0;
    end
    if (cmd.f2_fin) begin
      cur_nxt = $signed({1'b0, rjump});
    end
    if (cmd.f2_m1) begin
      cur_nxt = $signed({1'b0, rjump}) - 9'sd1;
    end
    if (cmd.end_fix && (cur_r > cnt_m1)) begin
      cur_nxt = '0;
    end
    if (cmd.adv) begin
      cur_nxt  = cur_r + 9'sd1;
      hold_nxt = '0;
    end
    if (cmd.set_hit) begin
      hit_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fc_r        <= '0;
      cur_r       <= '0;
      hold_r      <= '0;
      steps_r     <= '0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        fc_r <= cfg_data;
      end
      cur_r   <= cur_nxt;
      hold_r  <= hold_nxt;
      steps_r <= steps_nxt;
      hit_r   <= hit_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_cur_r  <= cur_r[CUR_W-1:0];
      out_hold_r <= hold_r;
      out_hit_r  <= hit_r;
    end
  end

  assign st.is_tick    = (op_t'(op) == OP_TICK);
  assign st.count_zero = (cnt == '0);
  assign st.hold_lt    = $signed({1'b0, hold_r}) < $signed(rdata[DUR_W-1:0]);
  assign st.f_jump     = is_jump_kind(rdata[23:16]);
  assign st.dur_pos    = $signed(rdata[DUR_W-1:0]) > 16'sd0;
  assign st.cap        = (steps_r >= CAP);
  assign st.at_end     = (cur_r >= cnt_m1);
  assign st.out_free   = !out_valid_r || out_ready;

  assign out_valid      = out_valid_r;
  assign current_frame  = out_cur_r;
  assign hold_count     = out_hold_r;
  assign step_limit_hit = out_hit_r;

endmodule

[sv/sprite_frame_sequencer.sv]
// channel  dir  handshake      payload
// in_ch    in   valid/ready    op, entry_index, entry_duration, entry_kind, entry_jump
// out_ch   out  valid/ready    current_frame, hold_count, step_limit_hit
// cfg_ch   in   valid/ready    data (frame_count), ready tied high
//
// A non-tick word goes from IDLE straight to DONE; a tick passes CHK, then ADV and F1L
// for each plain chain pass, with F2 added on a jump pass, since the frame table has a
// single registered read port.
// Reset is synchronous active-low; the frame table is not cleared.
// A word is taken only while no other is in work; a finished result sits in the
// output register, so the next word proceeds until its own result needs that slot.
module sprite_frame_sequencer import sfs_pkg::*; #(
  parameter int FRAMES = FRAMES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  sfs_in_if.sink    in_ch,
  sfs_out_if.source out_ch,
  sfs_cfg_if.sink   cfg_ch
);

  cmd_t cmd;
  sts_t st;

  assign cfg_ch.ready = 1'b1;

  sfs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .st       (st),
    .cmd      (cmd)
  );

  sfs_dp #(.FRAMES(FRAMES)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .st             (st),
    .cfg_valid      (cfg_ch.valid),
    .cfg_data       (cfg_ch.data),
    .op             (in_ch.op),
    .entry_index    (in_ch.entry_index),
    .entry_duration (in_ch.entry_duration),
    .entry_kind     (in_ch.entry_kind),
    .entry_jump     (in_ch.entry_jump),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .current_frame  (out_ch.current_frame),
    .hold_count     (out_ch.hold_count),
    .step_limit_hit (out_ch.step_limit_hit)
  );

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> st.out_free)
    else $error("result loaded over an untaken result");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("second word taken while one is in work");

  a_quick_ops: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && (in_ch.op != OP_TICK)) |=> (cmd.out_load == st.out_free))
    else $error("non-tick word did not finish at once");

  a_one_move: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.jmp1, cmd.adv, cmd.hold_inc, cmd.end_fix, cmd.f2_fin, cmd.f2_m1}))
    else $error("conflicting cursor updates");

endmodule

[verif/sprite_frame_sequencer_tb.sv]
`timescale 1ns / 1ps

module sprite_frame_sequencer_tb;
  import sfs_pkg::*;

  localparam int FRAMES = FRAMES_DEF;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int TAIL_CYCLES = 250;
  localparam longint TIMEOUT_NS = 30_000_000;
  localparam logic [OP_W-1:0] OP_UNUSED = 3'd5;

  typedef struct packed {
    logic [DUR_W-1:0]  dur;
    logic [KIND_W-1:0] kind;
    logic [JUMP_W-1:0] jump;
  } frame_t;

  typedef struct packed {
    logic [CUR_W-1:0]  frame;
    logic [HOLD_W-1:0] hold;
    logic              hit;
  } frame_result_t;

  typedef struct {
    bit                is_cfg;
    int                cnt;
    logic [OP_W-1:0]   op;
    logic [IDX_W-1:0]  idx;
    logic [DUR_W-1:0]  dur;
    logic [KIND_W-1:0] kind;
    logic [JUMP_W-1:0] jump;
    bit                typed;
    logic [CUR_W-1:0]  frame;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  sfs_in_if  in_ch ();
  sfs_out_if out_ch ();
  sfs_cfg_if cfg_ch ();

  sprite_frame_sequencer #(.FRAMES(FRAMES)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #6 clk = ~clk;

  // frame sequencer state as the testbench sees it
  frame_t            frames_mdl [FRAMES];
  logic [CUR_W-1:0]  cur_mdl;
  logic [HOLD_W-1:0] hold_mdl;
  logic [FCNT_W-1:0] fcount_mdl;

  frame_result_t pending_results[$];
  stim_row_t     plan[$];

  int  mismatches = 0;
  int  results_checked = 0;
  int  words_sent = 0;
  int  ticks_sent = 0;
  int  cap_hits = 0;
  int  count_settings = 0;
  bit  no_idle = 1'b0;
  bit  hold_req = 1'b0;

  function automatic int used_frames();
    return (fcount_mdl > FRAMES) ? FRAMES : int'(fcount_mdl);
  endfunction

  function automatic bit jump_kind(input logic [KIND_W-1:0] k);
    return (k == KIND_JUMP_A) || (k == KIND_JUMP_B) || (k == KIND_JUMP_C);
  endfunction

  function automatic void add_row(input stim_row_t r);
    plan.insert(plan.size(), r);
  endfunction

  function automatic frame_result_t apply_word(input logic [OP_W-1:0] op,
                                               input logic [IDX_W-1:0] idx,
                                               input logic [DUR_W-1:0] dur,
                                               input logic [KIND_W-1:0] kind,
                                               input logic [JUMP_W-1:0] jump);
    int     n, c, h, steps;
    bit     hit;
    frame_t f1, f2;
    n = used_frames();
    hit = 1'b0;
    case (op)
      OP_TICK: begin
        ticks_sent++;
        if (n > 0) begin
          c = int'(cur_mdl);
          h = int'(hold_mdl);
          steps = 0;
          f1 = frames_mdl[c < n ? c : 0];
          if (h < int'($signed(f1.dur))) begin
            hold_mdl = HOLD_W'(h + 1);
          end else begin
            forever begin
              steps++;
              if (jump_kind(f1.kind)) begin
                c = int'(f1.jump);
                f2 = frames_mdl[c >= n ? 0 : c];
                c = int'(f2.jump) - 1;
                h = 0;
                if (jump_kind(f2.kind)) begin
                  c = int'(f2.jump);
                  break;
                end
              end
              if (c >= n - 1) begin
                if (c > n - 1) c = 0;
                break;
              end
              c++;
              f1 = frames_mdl[c];
              h = 0;
              if (int'($signed(f1.dur)) > 0) break;
              if (steps >= FRAMES + 1) begin
                hit = 1'b1;
                break;
              end
            end
            cur_mdl = c[CUR_W-1:0];
            hold_mdl = h[HOLD_W-1:0];
          end
        end
      end
      OP_WRITE: if (idx < FRAMES) frames_mdl[idx] = '{dur, kind, jump};
      OP_RESET: begin
        cur_mdl = '0;
        hold_mdl = '0;
      end
      OP_FWD: if (n > 0) begin
        c = int'(cur_mdl) + 1;
        cur_mdl = (c >= n) ? '0 : c[CUR_W-1:0];
        hold_mdl = '0;
      end
      OP_BACK: if (n > 0) begin
        cur_mdl = (cur_mdl == 0) ? CUR_W'(n - 1) : cur_mdl - 1'b1;
        hold_mdl = '0;
      end
      default: ;
    endcase
    if (hit) cap_hits++;
    return '{cur_mdl, hold_mdl, hit};
  endfunction

  function automatic stim_row_t wrow(input logic [OP_W-1:0] op, input int idx, input int dur,
                                     input int kind, input int jump, input bit typed,
                                     input int frame);
    stim_row_t r;
    r.is_cfg = 1'b0;
    r.cnt = 0;
    r.op = op;
    r.idx = idx[IDX_W-1:0];
    r.dur = dur[DUR_W-1:0];
    r.kind = kind[KIND_W-1:0];
    r.jump = jump[JUMP_W-1:0];
    r.typed = typed;
    r.frame = frame[CUR_W-1:0];
    return r;
  endfunction

  function automatic stim_row_t crow(input int cnt);
    stim_row_t r;
    r = wrow(OP_TICK, 0, 0, 0, 0, 1'b0, 0);
    r.is_cfg = 1'b1;
    r.cnt = cnt;
    return r;
  endfunction

  task automatic send_word(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                           input logic [DUR_W-1:0] dur, input logic [KIND_W-1:0] kind,
                           input logic [JUMP_W-1:0] jump, input bit typed,
                           input logic [CUR_W-1:0] typed_frame);
    int            gap, r;
    frame_result_t predicted;
    r = $urandom_range(0, 99);
    if (no_idle || r < 70) gap = 0;
    else if (r < 95) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 40);
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid          <= 1'b1;
    in_ch.op             <= op;
    in_ch.entry_index    <= idx;
    in_ch.entry_duration <= dur;
    in_ch.entry_kind     <= kind;
    in_ch.entry_jump     <= jump;
    do @(posedge clk); while (!in_ch.ready);
    words_sent++;
    predicted = apply_word(op, idx, dur, kind, jump);
    if (typed) predicted = '{typed_frame, '0, 1'b0};
    pending_results.insert(pending_results.size(), predicted);
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_frame_count(input int v);
    drain();
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v[FCNT_W-1:0];
    do @(posedge clk); while (!cfg_ch.ready);
    fcount_mdl = v[FCNT_W-1:0];
    count_settings++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // small holds, plenty of zero-length and jump frames so chains get walked
  task automatic random_entry(output logic [DUR_W-1:0] dur, output logic [KIND_W-1:0] kind,
                              output logic [JUMP_W-1:0] jump);
    int n, r;
    n = used_frames();
    r = $urandom_range(0, 9);
    if (r < 5) dur = DUR_W'($urandom_range(0, 3) - 1);
    else if (r < 8) dur = DUR_W'($urandom_range(2, 6));
    else if (r == 8) dur = DUR_W'(-$urandom_range(2, 40));
    else dur = DUR_W'($urandom());
    r = $urandom_range(0, 19);
    if (r < 7) kind = KIND_W'($urandom_range(0, 3));
    else if (r < 9) kind = KIND_JUMP_A;
    else if (r < 11) kind = KIND_JUMP_B;
    else if (r < 13) kind = KIND_JUMP_C;
    else if (r < 15) kind = 8'hff;
    else kind = KIND_W'($urandom());
    if (n > 0 && $urandom_range(0, 9) < 7) jump = JUMP_W'($urandom_range(0, n - 1));
    else jump = JUMP_W'($urandom());
  endtask

  task automatic random_word();
    int                r;
    logic [OP_W-1:0]   op;
    logic [IDX_W-1:0]  idx;
    logic [DUR_W-1:0]  dur;
    logic [KIND_W-1:0] kind;
    logic [JUMP_W-1:0] jump;
    r = $urandom_range(0, 99);
    idx = IDX_W'($urandom());
    random_entry(dur, kind, jump);
    if (r < 55) op = OP_TICK;
    else if (r < 80) op = OP_WRITE;
    else if (r < 87) op = OP_FWD;
    else if (r < 94) op = OP_BACK;
    else if (r < 97) op = OP_RESET;
    else op = OP_BACK + OP_W'($urandom_range(1, 3));
    send_word(op, idx, dur, kind, jump, 1'b0, '0);
  endtask

  // result sink: random backpressure, plus a long hold-off on request
  initial begin
    int stall, r;
    stall = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        stall = HOLD_OFF_CYCLES;
      end
      if (stall > 0) begin
        stall--;
        out_ch.ready <= 1'b0;
      end else if (no_idle) begin
        out_ch.ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          out_ch.ready <= 1'b1;
        end else begin
          out_ch.ready <= 1'b0;
          stall = (r < 95) ? $urandom_range(0, 3) : $urandom_range(10, 40);
        end
      end
    end
  end

  always @(posedge clk) begin
    frame_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_checked++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected word: frame=%0d hold=%0d hit=%0b", $realtime,
                   out_ch.current_frame, out_ch.hold_count, out_ch.step_limit_hit);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.current_frame !== want.frame || out_ch.hold_count !== want.hold ||
            out_ch.step_limit_hit !== want.hit) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] mismatch: exp %0d/%0d/%0b, got %0d/%0d/%0b (frame/hold/hit)",
                     $realtime, want.frame, want.hold, want.hit, out_ch.current_frame,
                     out_ch.hold_count, out_ch.step_limit_hit);
        end
      end
    end
  end

  initial begin
    int cnt_plan[20];
    cnt_plan = '{64, 127, 1, 0, 5, 64, 2, 33, 100, 13, 64, 7, 50, 3, 64, 20, 127, 9, 64, 40};

    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.op             = OP_TICK;
    in_ch.entry_index    = '0;
    in_ch.entry_duration = '0;
    in_ch.entry_kind     = '0;
    in_ch.entry_jump     = '0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.data          = '0;
    cur_mdl              = '0;
    hold_mdl             = '0;
    fcount_mdl           = '0;
    foreach (frames_mdl[i]) frames_mdl[i] = '0;

    // idle block: everything reports zero
    add_row(wrow(OP_TICK,   0, 0, 0, 0, 1'b1, 0));
    add_row(wrow(OP_FWD,    0, 0, 0, 0, 1'b1, 0));
    add_row(wrow(OP_BACK,   0, 0, 0, 0, 1'b1, 0));
    add_row(wrow(OP_UNUSED, 0, 0, 0, 0, 1'b1, 0));
    add_row(wrow(OP_WRITE,  0, 1, 0, 0, 1'b1, 0));
    add_row(wrow(OP_WRITE,  1, 0, 0, 0, 1'b1, 0));
    add_row(wrow(OP_WRITE,  2, -32768, KIND_JUMP_A, 5, 1'b1, 0));
    add_row(wrow(OP_WRITE,  3, 32767, 255, 255, 1'b1, 0));
    add_row(wrow(OP_WRITE,  4, 2, KIND_JUMP_B, 0, 1'b1, 0));
    add_row(wrow(OP_WRITE,  5, 0, KIND_JUMP_C, 3, 1'b1, 0));
    add_row(crow(6));
    // hold, then zero-length chain into a two-level jump
    add_row(wrow(OP_TICK,   0, 0, 0, 0, 1'b0, 0));
    add_row(wrow(OP_TICK,   0, 0, 0, 0, 1'b0, 0));
    add_row(wrow(OP_TICK,   0, 0, 0, 0, 1'b0, 0));
    add_row(wrow(OP_FWD,    0, 0, 0, 0, 1'b0, 0));
    add_row(wrow(OP_BACK,   0, 0, 0, 0, 1'b0, 0));
    add_row(wrow(OP_RESET,  0, 0, 0, 0, 1'b1, 0));
    add_row(wrow(OP_BACK,   0, 0, 0, 0, 1'b1, 5));
    add_row(wrow(OP_FWD,    0, 0, 0, 0, 1'b1, 0));
    add_row(wrow(OP_BACK,   0, 0, 0, 0, 1'b1, 5));
    // cursor past the end once frame_count shrinks
    add_row(crow(3));
    add_row(wrow(OP_TICK,   0, 0, 0, 0, 1'b0, 0));
    add_row(wrow(OP_TICK,   0, 0, 0, 0, 1'b0, 0));
    // zero-length jump loop, runs into the chain cap
    add_row(wrow(OP_WRITE,  0, 0, KIND_JUMP_A, 1, 1'b0, 0));
    add_row(wrow(OP_WRITE,  1, 0, 0, 0, 1'b0, 0));
    add_row(crow(2));
    add_row(wrow(OP_TICK,   0, 0, 0, 0, 1'b0, 0));
    add_row(wrow(OP_TICK,   0, 0, 0, 0, 1'b0, 0));

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) set_frame_count(plan[i].cnt);
      else send_word(plan[i].op, plan[i].idx, plan[i].dur, plan[i].kind, plan[i].jump,
                     plan[i].typed, plan[i].frame);
    end

    // fill the whole table before any random tick reads it
    set_frame_count(FRAMES);
    for (int i = 0; i < FRAMES; i++) begin
      logic [DUR_W-1:0]  dur;
      logic [KIND_W-1:0] kind;
      logic [JUMP_W-1:0] jump;
      random_entry(dur, kind, jump);
      send_word(OP_WRITE, IDX_W'(i), dur, kind, jump, 1'b0, '0);
    end

    for (int p = 0; p < 20; p++) begin
      set_frame_count(cnt_plan[p]);
      no_idle = (p % 4 == 1);
      if (p % 8 == 5) hold_req = 1'b1;
      repeat (90) random_word();
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      mismatches++;
      $display("%0d expected words never came out", pending_results.size());
    end
    $display("%0d words (%0d ticks, %0d chain-cap hits) over %0d frame_count settings",
             words_sent, ticks_sent, cap_hits, count_settings);
    $display("%0d results checked, %0d mismatches", results_checked, mismatches);
    if (mismatches == 0) begin
      $display("sprite_frame_sequencer_tb: clean");
    end else begin
      $display("sprite_frame_sequencer_tb: errors");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("timeout at %0t", $realtime);
    $display("sprite_frame_sequencer_tb: errors");
    $finish;
  end

endmodule
